@@ rtl/core/fnf_pkg.sv @@
// Shared types and codes of the first/next fit partition allocator.
package fnf_pkg;

    // Fixed field widths of the stream items.
    localparam int PID_IN_W = 4;
    localparam int RND_W    = 16;
    localparam int STAT_W   = 3;

    // Operation carried in tuser.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 3'd0,
        ST_NO_FIT   = 3'd1,
        ST_FULL     = 3'd2,
        ST_HOLDS    = 3'd3,
        ST_NOT_HELD = 3'd4,
        ST_ZERO     = 3'd5
    } t_status;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_SRD,
        S_SCHK,
        S_DIV,
        S_PLAN,
        S_UPRD,
        S_UPWR,
        S_AW0,
        S_AW1,
        S_AW2,
        S_RNRD,
        S_RNCK,
        S_RPRD,
        S_RPCK,
        S_RPLAN,
        S_DNRD,
        S_DNWR,
        S_FIN
    } t_state;

endpackage

@@ rtl/core/fnf_rem.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module fnf_rem #(
    parameter int DW = 16,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [VW-1:0] o_rem
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_num;
    logic [VW-1:0]    r_d;
    logic [VW:0]      w_trial;

    // Shift the next dividend bit into the partial remainder.
    assign w_trial = {r_rem, r_num[DW-1]};

    // Control: count down the dividend bits while busy, then flag done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: subtract the divisor whenever it fits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            if (w_trial >= {1'b0, r_d}) begin
                r_rem <= VW'(w_trial - {1'b0, r_d});
            end else begin
                r_rem <= w_trial[VW-1:0];
            end
            r_num <= {r_num[DW-2:0], 1'b0};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/first_next_fit_partition_allocator.sv @@
// Top level of the first/next fit variable partition allocator.
//
// Requests arrive on the s_axis channel: tuser is the operation (allocate
// or release), tdata carries process, size and a random word. Each request
// gives exactly one result on m_axis: status, granted start and size.
// The user writes fit_mode through i_cfg_we / i_cfg_wdata only while the
// block idles; the block itself does not enforce it. The segment table
// lives in one memory with a registered read port; a sequencer reads,
// modifies and writes it back one entry at a time. Allocate searches the
// segments, computes the placement remainder, moves entries up and writes
// the granted segment and any remainders; release searches the segments,
// reads the neighbours, writes the merged free segment and moves entries
// down. Errors found from the process table answer without a search. One
// request is in work at a time. After reset, entry zero reads as the whole
// memory free until it is first written. A stalled receiver holds the
// result in the output register; the next request is still taken, and its
// result waits until the previous transfer has completed.
module first_next_fit_partition_allocator #(
    parameter int MEM_UNITS    = 1024,
    parameter int PROCESSES    = 16,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // process_id, request_size, random_word, zero padding
    input  logic [((fnf_pkg::PID_IN_W + $clog2(MEM_UNITS) + 1 + fnf_pkg::RND_W + 7) / 8) * 8
                  - 1:0] s_axis_tdata,
    // operation
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, granted_start, granted_size, zero padding
    output logic [((fnf_pkg::STAT_W + 2 * $clog2(MEM_UNITS) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int ADDR_W = $clog2(MEM_UNITS);
    localparam int REQ_W  = ADDR_W + 1;
    localparam int IW     = $clog2(MAX_SEGMENTS);
    localparam int CW     = $clog2(MAX_SEGMENTS + 1);
    localparam int PID_W  = $clog2(PROCESSES);
    localparam int IN_W   = ((fnf_pkg::PID_IN_W + REQ_W + fnf_pkg::RND_W + 7) / 8) * 8;
    localparam int OUT_W  = ((fnf_pkg::STAT_W + ADDR_W + REQ_W + 7) / 8) * 8;
    localparam int RQ_LO  = fnf_pkg::PID_IN_W;
    localparam int RN_LO  = RQ_LO + REQ_W;

    typedef struct packed {
        logic              free;
        logic [PID_W-1:0]  owner;
        logic [ADDR_W-1:0] start;
        logic [REQ_W-1:0]  size;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);
    localparam t_seg SEG_INIT = '{free: 1'b1, owner: '0, start: '0, size: REQ_W'(MEM_UNITS)};

    // Process number folded into the table range by repeated subtraction.
    function automatic logic [PID_W-1:0] pid_fold(input logic [fnf_pkg::PID_IN_W-1:0] pid);
        logic [fnf_pkg::PID_IN_W:0] v;
        v = {1'b0, pid};
        for (int k = 0; k < 8; k++) begin
            if (v >= (fnf_pkg::PID_IN_W + 1)'(PROCESSES)) begin
                v = v - (fnf_pkg::PID_IN_W + 1)'(PROCESSES);
            end
        end
        return PID_W'(v);
    endfunction

    fnf_pkg::t_state r_state, n_state;

    // Control registers.
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_rov, n_rov;
    logic          r_fit;
    logic          r_e0_wr;
    logic          r_ov, n_ov;
    logic          r_holds [PROCESSES];
    logic [ADDR_W-1:0] r_own_start [PROCESSES];

    // Request and work registers.
    logic                       r_op;
    logic [PID_W-1:0]           r_pid;
    logic [REQ_W-1:0]           r_req;
    logic [fnf_pkg::RND_W-1:0]  r_rnd;
    logic [CW-1:0]              r_k, n_k;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_i, n_i;
    logic [CW-1:0]              r_sp, n_sp;
    logic [CW-1:0]              r_lim, n_lim;
    t_seg                       r_seg, n_seg;
    t_seg                       r_nb, n_nb;
    t_seg                       r_pv, n_pv;
    logic                       r_nfree, n_nfree;
    logic                       r_pfree, n_pfree;
    logic [REQ_W-1:0]           r_off, n_off;
    logic [REQ_W-1:0]           r_tail, n_tail;
    logic [1:0]                 r_need, n_need;
    fnf_pkg::t_status           r_st, n_st;
    logic [ADDR_W-1:0]          r_gs, n_gs;
    logic [REQ_W-1:0]           r_gz, n_gz;
    logic [OUT_W-1:0]           r_out, n_out;

    // Owner table update request.
    logic              own_clr;
    logic              own_set;
    logic [ADDR_W-1:0] own_set_start;

    // Segment memory and its ports.
    logic [SEG_W-1:0] r_mem [MAX_SEGMENTS];
    logic [SEG_W-1:0] r_mem_q;
    logic             r_rd_init;
    logic [IW-1:0]    mem_ra;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    t_seg             mem_wd;
    t_seg             seg_rd;

    // Remainder unit.
    logic             div_start;
    logic             div_done;
    logic [REQ_W-1:0] div_rem;
    logic [REQ_W-1:0] div_d;

    // Shared conditions.
    logic              s_take;
    logic              own_holds;
    logic [ADDR_W-1:0] own_start;
    logic              w_match;
    logic              w_last;
    logic [CW-1:0]     w_kn;
    logic [CW-1:0]     w_next_idx;
    logic [CW-1:0]     w_newcnt;
    logic              w_full;
    logic [CW-1:0]     w_a;
    logic [1:0]        w_rem_cnt;
    logic              w_fin_load;

    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == fnf_pkg::S_IDLE);
    assign own_holds     = r_holds[r_pid];
    assign own_start     = r_own_start[r_pid];
    assign seg_rd        = r_rd_init ? SEG_INIT : t_seg'(r_mem_q);

    // Search match for either operation.
    always_comb begin
        if (r_op == fnf_pkg::OP_ALLOC) begin
            w_match = seg_rd.free && (seg_rd.size >= r_req);
        end else begin
            w_match = !seg_rd.free && (seg_rd.owner == r_pid) && (seg_rd.start == own_start);
        end
    end

    assign w_kn       = r_k + 1'b1;
    assign w_last     = (w_kn == r_cnt);
    assign w_next_idx = ((r_idx + 1'b1) == r_cnt) ? '0 : r_idx + 1'b1;
    assign w_newcnt   = r_cnt + CW'(r_need);
    assign w_full     = ((CW + 1)'(r_cnt) + (CW + 1)'(r_need)) > (CW + 1)'(MAX_SEGMENTS);
    assign w_a        = r_i + CW'(r_off != '0);
    assign w_rem_cnt  = {1'b0, r_nfree} + {1'b0, r_pfree};
    assign w_fin_load = !r_ov || m_axis_tready;
    assign div_d      = (seg_rd.size - r_req) + 1'b1;
    assign div_start  = (r_state == fnf_pkg::S_SCHK) && w_match && (r_op == fnf_pkg::OP_ALLOC);

    fnf_rem #(
        .DW (fnf_pkg::RND_W),
        .VW (REQ_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rnd),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fnf_pkg::S_IDLE: begin
                if (s_take) n_state = fnf_pkg::S_START;
            end
            fnf_pkg::S_START: begin
                if (r_op == fnf_pkg::OP_ALLOC) begin
                    n_state = (r_req == '0 || own_holds) ? fnf_pkg::S_FIN : fnf_pkg::S_SRD;
                end else begin
                    n_state = own_holds ? fnf_pkg::S_SRD : fnf_pkg::S_FIN;
                end
            end
            fnf_pkg::S_SRD: n_state = fnf_pkg::S_SCHK;
            fnf_pkg::S_SCHK: begin
                if (w_match) begin
                    n_state = (r_op == fnf_pkg::OP_ALLOC) ? fnf_pkg::S_DIV : fnf_pkg::S_RNRD;
                end else if (w_last) begin
                    n_state = fnf_pkg::S_FIN;
                end else begin
                    n_state = fnf_pkg::S_SRD;
                end
            end
            fnf_pkg::S_DIV: begin
                if (div_done) n_state = fnf_pkg::S_PLAN;
            end
            fnf_pkg::S_PLAN: begin
                if (w_full) begin
                    n_state = fnf_pkg::S_FIN;
                end else if (r_need != '0 && (r_cnt - 1'b1) > r_i) begin
                    n_state = fnf_pkg::S_UPRD;
                end else begin
                    n_state = fnf_pkg::S_AW0;
                end
            end
            fnf_pkg::S_UPRD: n_state = fnf_pkg::S_UPWR;
            fnf_pkg::S_UPWR: begin
                n_state = ((r_sp - 1'b1) > r_i) ? fnf_pkg::S_UPRD : fnf_pkg::S_AW0;
            end
            fnf_pkg::S_AW0:  n_state = fnf_pkg::S_AW1;
            fnf_pkg::S_AW1:  n_state = fnf_pkg::S_AW2;
            fnf_pkg::S_AW2:  n_state = fnf_pkg::S_FIN;
            fnf_pkg::S_RNRD: begin
                n_state = ((r_i + 1'b1) < r_cnt) ? fnf_pkg::S_RNCK : fnf_pkg::S_RPRD;
            end
            fnf_pkg::S_RNCK: n_state = fnf_pkg::S_RPRD;
            fnf_pkg::S_RPRD: begin
                n_state = (r_i != '0) ? fnf_pkg::S_RPCK : fnf_pkg::S_RPLAN;
            end
            fnf_pkg::S_RPCK: n_state = fnf_pkg::S_RPLAN;
            fnf_pkg::S_RPLAN: begin
                n_state = (w_rem_cnt == '0) ? fnf_pkg::S_FIN : fnf_pkg::S_DNRD;
            end
            fnf_pkg::S_DNRD: begin
                n_state = (r_sp < r_lim) ? fnf_pkg::S_DNWR : fnf_pkg::S_FIN;
            end
            fnf_pkg::S_DNWR: n_state = fnf_pkg::S_DNRD;
            fnf_pkg::S_FIN: begin
                if (w_fin_load) n_state = fnf_pkg::S_IDLE;
            end
            default: n_state = fnf_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        logic [CW-1:0] rt;
        rt            = r_rov;
        n_cnt         = r_cnt;
        n_rov         = r_rov;
        n_k           = r_k;
        n_idx         = r_idx;
        n_i           = r_i;
        n_sp          = r_sp;
        n_lim         = r_lim;
        n_seg         = r_seg;
        n_nb          = r_nb;
        n_pv          = r_pv;
        n_nfree       = r_nfree;
        n_pfree       = r_pfree;
        n_off         = r_off;
        n_tail        = r_tail;
        n_need        = r_need;
        n_st          = r_st;
        n_gs          = r_gs;
        n_gz          = r_gz;
        n_out         = r_out;
        n_ov          = r_ov;
        own_clr       = 1'b0;
        own_set       = 1'b0;
        own_set_start = r_seg.start + ADDR_W'(r_off);
        mem_ra        = r_idx[IW-1:0];
        mem_we        = 1'b0;
        mem_wa        = r_i[IW-1:0];
        mem_wd        = r_seg;

        // Output register empties on a completed transfer.
        if (r_ov && m_axis_tready) n_ov = 1'b0;

        unique case (r_state)
            fnf_pkg::S_IDLE: begin
            end
            fnf_pkg::S_START: begin
                n_gs  = '0;
                n_gz  = '0;
                n_k   = '0;
                n_st  = fnf_pkg::ST_DONE;
                n_idx = '0;
                if (r_op == fnf_pkg::OP_ALLOC) begin
                    if (r_req == '0) begin
                        n_st = fnf_pkg::ST_ZERO;
                    end else if (own_holds) begin
                        n_st = fnf_pkg::ST_HOLDS;
                    end else if (r_fit && r_rov < r_cnt) begin
                        n_idx = r_rov;
                    end
                end else if (!own_holds) begin
                    n_st = fnf_pkg::ST_NOT_HELD;
                end
            end
            fnf_pkg::S_SRD: begin
                mem_ra = r_idx[IW-1:0];
            end
            fnf_pkg::S_SCHK: begin
                if (w_match) begin
                    n_i   = r_idx;
                    n_seg = seg_rd;
                    if (r_op == fnf_pkg::OP_RELEASE) begin
                        n_gs    = seg_rd.start;
                        n_gz    = seg_rd.size;
                        own_clr = 1'b1;
                    end
                end else if (w_last) begin
                    if (r_op == fnf_pkg::OP_ALLOC) begin
                        n_st = fnf_pkg::ST_NO_FIT;
                    end else begin
                        n_st    = fnf_pkg::ST_NOT_HELD;
                        own_clr = 1'b1;
                    end
                end else begin
                    n_k   = w_kn;
                    n_idx = w_next_idx;
                end
            end
            fnf_pkg::S_DIV: begin
                if (div_done) begin
                    n_off  = div_rem;
                    n_tail = (r_seg.size - r_req) - div_rem;
                    n_need = {1'b0, div_rem != '0} +
                             {1'b0, ((r_seg.size - r_req) - div_rem) != '0};
                end
            end
            fnf_pkg::S_PLAN: begin
                if (w_full) begin
                    n_st = fnf_pkg::ST_FULL;
                end else begin
                    // Roving index follows its segment across the inserts; in next fit mode it moves past the grant.
                    if (r_off != '0 && rt >= r_i) rt = rt + 1'b1;
                    if (r_tail != '0 && rt >= w_a + 1'b1) rt = rt + 1'b1;
                    if (r_fit) rt = ((w_a + 1'b1) >= w_newcnt) ? '0 : w_a + 1'b1;
                    n_rov = rt;
                    n_sp  = r_cnt - 1'b1;
                    n_cnt = w_newcnt;
                end
            end
            fnf_pkg::S_UPRD: begin
                mem_ra = r_sp[IW-1:0];
            end
            fnf_pkg::S_UPWR: begin
                mem_we = 1'b1;
                mem_wa = IW'(r_sp + CW'(r_need));
                mem_wd = seg_rd;
                n_sp   = r_sp - 1'b1;
            end
            fnf_pkg::S_AW0: begin
                // Leading remainder or the granted segment at the found slot.
                mem_we = 1'b1;
                mem_wa = r_i[IW-1:0];
                if (r_off != '0) begin
                    mem_wd = '{free: 1'b1, owner: '0, start: r_seg.start, size: r_off};
                end else begin
                    mem_wd = '{free: 1'b0, owner: r_pid, start: r_seg.start, size: r_req};
                end
                own_set = 1'b1;
                n_gs    = own_set_start;
                n_gz    = r_req;
                n_st    = fnf_pkg::ST_DONE;
            end
            fnf_pkg::S_AW1: begin
                mem_we = (r_off != '0);
                mem_wa = IW'(r_i + 1'b1);
                mem_wd = '{free: 1'b0, owner: r_pid, start: own_set_start, size: r_req};
            end
            fnf_pkg::S_AW2: begin
                mem_we = (r_tail != '0);
                mem_wa = IW'(w_a + 1'b1);
                mem_wd = '{free: 1'b1, owner: '0,
                           start: own_set_start + ADDR_W'(r_req), size: r_tail};
            end
            fnf_pkg::S_RNRD: begin
                mem_ra  = IW'(r_i + 1'b1);
                n_nfree = 1'b0;
            end
            fnf_pkg::S_RNCK: begin
                n_nb    = seg_rd;
                n_nfree = seg_rd.free;
            end
            fnf_pkg::S_RPRD: begin
                mem_ra  = IW'(r_i - 1'b1);
                n_pfree = 1'b0;
            end
            fnf_pkg::S_RPCK: begin
                n_pv    = seg_rd;
                n_pfree = seg_rd.free;
            end
            fnf_pkg::S_RPLAN: begin
                // Write the merged free segment and plan the closing shift.
                mem_we = 1'b1;
                mem_wa = r_pfree ? IW'(r_i - 1'b1) : r_i[IW-1:0];
                mem_wd = '{free: 1'b1, owner: '0,
                           start: r_pfree ? r_pv.start : r_seg.start,
                           size: (r_pfree ? r_pv.size : '0) + r_seg.size +
                                 (r_nfree ? r_nb.size : '0)};
                if (r_nfree) begin
                    if (rt == r_i + 1'b1) rt = r_i;
                    else if (rt > r_i + 1'b1) rt = rt - 1'b1;
                end
                if (r_pfree) begin
                    if (rt == r_i) rt = r_i - 1'b1;
                    else if (rt > r_i) rt = rt - 1'b1;
                end
                n_rov = rt;
                n_sp  = r_nfree ? r_i + CW'(2) : r_i + 1'b1;
                n_lim = r_cnt;
                n_cnt = r_cnt - CW'(w_rem_cnt);
                n_st  = fnf_pkg::ST_DONE;
            end
            fnf_pkg::S_DNRD: begin
                mem_ra = r_sp[IW-1:0];
            end
            fnf_pkg::S_DNWR: begin
                mem_we = 1'b1;
                mem_wa = IW'(r_sp - CW'(w_rem_cnt));
                mem_wd = seg_rd;
                n_sp   = r_sp + 1'b1;
            end
            fnf_pkg::S_FIN: begin
                if (w_fin_load) begin
                    n_ov  = 1'b1;
                    n_out = OUT_W'({r_gz, r_gs, r_st});
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fnf_pkg::S_IDLE;
            r_cnt   <= CW'(1);
            r_rov   <= '0;
            r_fit   <= 1'b0;
            r_e0_wr <= 1'b0;
            r_ov    <= 1'b0;
            for (int p = 0; p < PROCESSES; p++) begin
                r_holds[p] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rov   <= n_rov;
            r_ov    <= n_ov;
            if (i_cfg_we) r_fit <= i_cfg_wdata;
            if (mem_we && mem_wa == '0) r_e0_wr <= 1'b1;
            if (own_set) begin
                r_holds[r_pid] <= 1'b1;
            end else if (own_clr) begin
                r_holds[r_pid] <= 1'b0;
            end
        end
    end

    // Payload and work registers.
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_op  <= s_axis_tuser;
            r_pid <= pid_fold(s_axis_tdata[fnf_pkg::PID_IN_W-1:0]);
            r_req <= s_axis_tdata[RN_LO-1:RQ_LO];
            r_rnd <= s_axis_tdata[RN_LO+fnf_pkg::RND_W-1:RN_LO];
        end
        if (own_set) r_own_start[r_pid] <= own_set_start;
        r_k     <= n_k;
        r_idx   <= n_idx;
        r_i     <= n_i;
        r_sp    <= n_sp;
        r_lim   <= n_lim;
        r_seg   <= n_seg;
        r_nb    <= n_nb;
        r_pv    <= n_pv;
        r_nfree <= n_nfree;
        r_pfree <= n_pfree;
        r_off   <= n_off;
        r_tail  <= n_tail;
        r_need  <= n_need;
        r_st    <= n_st;
        r_gs    <= n_gs;
        r_gz    <= n_gz;
        r_out   <= n_out;
    end

    // Segment memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_mem_q   <= r_mem[mem_ra];
        r_rd_init <= (mem_ra == '0) && !r_e0_wr;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // Input padding bits carry nothing.
    logic w_unused_pad;
    assign w_unused_pad = ^s_axis_tdata[IN_W-1:RN_LO+fnf_pkg::RND_W] ^ (IN_W == 0);

endmodule

@@ rtl/core/fnf_chk.sv @@
// Port-level checker of the allocator result stream, bound to the top level.
module fnf_chk #(
    parameter int MEM_UNITS = 1024
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((fnf_pkg::STAT_W + 2 * $clog2(MEM_UNITS) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int ADDR_W = $clog2(MEM_UNITS);
    localparam int REQ_W  = ADDR_W + 1;
    localparam int ST_HI  = fnf_pkg::STAT_W - 1;
    localparam int GZ_LO  = fnf_pkg::STAT_W + ADDR_W;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Refused requests report neither start nor size.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[ST_HI:0] != fnf_pkg::ST_DONE
        |-> m_axis_tdata[GZ_LO+REQ_W-1:fnf_pkg::STAT_W] == '0)
        else $error("error result carries a grant");

    // A completed request always names a non-empty segment.
    a_done_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[ST_HI:0] == fnf_pkg::ST_DONE
        |-> m_axis_tdata[GZ_LO+REQ_W-1:GZ_LO] != '0)
        else $error("completed request with empty segment");

    // No result is offered straight after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind first_next_fit_partition_allocator fnf_chk #(.MEM_UNITS(MEM_UNITS)) u_fnf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
